FILE: rtl/h2d_pkg.sv
// ----------------------------------------------------------------------------
// h2d_pkg
// Shared types and constants for the one-level 2D Haar block over a grid
// with undefined cells.
// ----------------------------------------------------------------------------
package h2d_pkg;

  // sample and coordinate widths
  localparam int SAMPLE_W   = 24;
  localparam int COORD_W    = 6;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SAMPLE_W;

  // default grid limits
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_COLS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_ROWS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MISSING_MARKER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_ON_MISSING = 3'd5;

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // input word
  typedef struct packed {
    logic                       action;
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         col;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  // result word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] approx_coef;
    logic signed [SAMPLE_W-1:0] horiz_coef;
    logic signed [SAMPLE_W-1:0] vert_coef;
    logic signed [SAMPLE_W-1:0] diag_coef;
  } out_item_t;

  // configuration register set
  typedef struct packed {
    logic [SIZE_W-1:0]          cols_in_use;
    logic [SIZE_W-1:0]          rows_in_use;
    logic                       pad_cols;
    logic                       pad_rows;
    logic signed [SAMPLE_W-1:0] missing_marker;
    logic                       swap_on_missing;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic       store;
    logic       load;
    logic       fetch;
    logic [1:0] fetch_idx;
    logic       cap;
    logic [1:0] cap_idx;
    logic       col_pass;
    logic       row_pass;
  } ctl_cmd_t;

endpackage

FILE: rtl/h2d_ctrl.sv
// ----------------------------------------------------------------------------
// h2d_ctrl
// Sequencer: accepts words, walks the four cell fetches of a block read,
// then the column and row passes.
// ----------------------------------------------------------------------------
module h2d_ctrl import h2d_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     action,
  output logic     busy,
  output ctl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_F0   = 3'd1;
  localparam logic [2:0] S_F1   = 3'd2;
  localparam logic [2:0] S_F2   = 3'd3;
  localparam logic [2:0] S_F3   = 3'd4;
  localparam logic [2:0] S_CAP  = 3'd5;
  localparam logic [2:0] S_COLP = 3'd6;
  localparam logic [2:0] S_ROWP = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        cmd.store = accept && (action == ACT_WRITE);
        cmd.load  = accept && (action == ACT_READ);
        if (accept && (action == ACT_READ)) begin
          state_nxt = S_F0;
        end
      end
      S_F0: begin
        cmd.fetch     = 1'b1;
        cmd.fetch_idx = 2'd0;
        state_nxt     = S_F1;
      end
      S_F1: begin
        cmd.fetch     = 1'b1;
        cmd.fetch_idx = 2'd1;
        cmd.cap       = 1'b1;
        cmd.cap_idx   = 2'd0;
        state_nxt     = S_F2;
      end
      S_F2: begin
        cmd.fetch     = 1'b1;
        cmd.fetch_idx = 2'd2;
        cmd.cap       = 1'b1;
        cmd.cap_idx   = 2'd1;
        state_nxt     = S_F3;
      end
      S_F3: begin
        cmd.fetch     = 1'b1;
        cmd.fetch_idx = 2'd3;
        cmd.cap       = 1'b1;
        cmd.cap_idx   = 2'd2;
        state_nxt     = S_CAP;
      end
      S_CAP: begin
        cmd.cap     = 1'b1;
        cmd.cap_idx = 2'd3;
        state_nxt   = S_COLP;
      end
      S_COLP: begin
        cmd.col_pass = 1'b1;
        state_nxt    = S_ROWP;
      end
      S_ROWP: begin
        cmd.row_pass = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/h2d_dp.sv
// ----------------------------------------------------------------------------
// h2d_dp
// Datapath: sample grid memory, padding and bounds logic, cell registers
// and the two Haar pair passes.
// ----------------------------------------------------------------------------
module h2d_dp import h2d_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctl_cmd_t  cmd,
  input  in_item_t  in_item,
  input  cfg_t      cfg,
  output out_item_t out_item,
  output logic      out_valid
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  // pair pass: half sum / half difference; on a missing value, pass or swap
  function automatic logic [2*SAMPLE_W-1:0] pair_pass(
    input logic signed [SAMPLE_W-1:0] first,
    input logic signed [SAMPLE_W-1:0] second,
    input logic signed [SAMPLE_W-1:0] marker,
    input logic                       swap
  );
    logic signed [SAMPLE_W:0] sum;
    logic signed [SAMPLE_W:0] dif;
    sum = {first[SAMPLE_W-1], first} + {second[SAMPLE_W-1], second};
    dif = {first[SAMPLE_W-1], first} - {second[SAMPLE_W-1], second};
    if ((first != marker) && (second != marker)) begin
      pair_pass = {sum[SAMPLE_W:1], dif[SAMPLE_W:1]};
    end else if (swap) begin
      pair_pass = {second, first};
    end else begin
      pair_pass = {first, second};
    end
  endfunction

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic                       oob_r;
  logic [COORD_W-1:0]         blk_row_r;
  logic [COORD_W-1:0]         blk_col_r;
  logic signed [SAMPLE_W-1:0] cell_r [4];
  logic signed [SAMPLE_W-1:0] a0_r, d0_r, a1_r, d1_r;
  out_item_t                  out_r;
  logic                       out_valid_r;

  logic [SIZE_W-1:0] w_use;
  logic [SIZE_W-1:0] h_use;
  logic [SIZE_W-1:0] x_raw, y_raw, x_eff, y_eff;
  logic              oob;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_ok;
  logic [2*SAMPLE_W-1:0] p0, p1, q0, q1;

  // width and height in use, clipped to storage
  assign w_use = (32'(cfg.cols_in_use) < MAX_COLS) ? cfg.cols_in_use : SIZE_W'(MAX_COLS);
  assign h_use = (32'(cfg.rows_in_use) < MAX_ROWS) ? cfg.rows_in_use : SIZE_W'(MAX_ROWS);

  // cell coordinates of the fetched cell, with padding and bounds
  always_comb begin
    x_raw = {blk_col_r, cmd.fetch_idx[0]};
    y_raw = {blk_row_r, cmd.fetch_idx[1]};
    x_eff = x_raw;
    y_eff = y_raw;
    if ((x_raw == w_use) && cfg.pad_cols) begin
      x_eff = w_use - SIZE_W'(1);
    end
    if ((y_raw == h_use) && cfg.pad_rows) begin
      y_eff = h_use - SIZE_W'(1);
    end
    oob = (w_use == '0) || (h_use == '0) || (x_eff >= w_use) || (y_eff >= h_use);
  end

  assign rd_addr = ADDR_W'(y_eff) * ADDR_W'(MAX_COLS) + ADDR_W'(x_eff);
  assign wr_addr = ADDR_W'(in_item.row) * ADDR_W'(MAX_COLS) + ADDR_W'(in_item.col);
  assign wr_ok   = (32'(in_item.row) < MAX_ROWS) && (32'(in_item.col) < MAX_COLS);

  // grid memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store && wr_ok) begin
      mem[wr_addr] <= in_item.sample;
    end
    if (cmd.fetch) begin
      rd_data_r <= mem[rd_addr];
      oob_r     <= oob;
    end
  end

  // hold block coordinates, capture cells
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      blk_row_r <= in_item.row;
      blk_col_r <= in_item.col;
    end
    if (cmd.cap) begin
      cell_r[cmd.cap_idx] <= oob_r ? cfg.missing_marker : rd_data_r;
    end
  end

  // column pass pairs the two rows, row pass pairs the column results
  assign p0 = pair_pass(cell_r[0], cell_r[2], cfg.missing_marker, cfg.swap_on_missing);
  assign p1 = pair_pass(cell_r[1], cell_r[3], cfg.missing_marker, cfg.swap_on_missing);
  assign q0 = pair_pass(a0_r, a1_r, cfg.missing_marker, cfg.swap_on_missing);
  assign q1 = pair_pass(d0_r, d1_r, cfg.missing_marker, cfg.swap_on_missing);

  always_ff @(posedge clk) begin
    if (cmd.col_pass) begin
      a0_r <= p0[2*SAMPLE_W-1:SAMPLE_W];
      d0_r <= p0[SAMPLE_W-1:0];
      a1_r <= p1[2*SAMPLE_W-1:SAMPLE_W];
      d1_r <= p1[SAMPLE_W-1:0];
    end
    if (cmd.row_pass) begin
      out_r.approx_coef <= q0[2*SAMPLE_W-1:SAMPLE_W];
      out_r.horiz_coef  <= q0[SAMPLE_W-1:0];
      out_r.vert_coef   <= q1[2*SAMPLE_W-1:SAMPLE_W];
      out_r.diag_coef   <= q1[SAMPLE_W-1:0];
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.row_pass;
    end
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/haar_2d_decompose_with_gaps.sv
// Write word: busy stays low and a new word may start the next cycle.
// Read word: busy stays high until the read is through: four cell fetches on the
//   single grid read port, the column and row passes; the result strobe follows.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Synchronous active-low reset clears the sequencer and strobe and loads the
//   configuration registers with defaults; grid contents are undefined until written.
// ----------------------------------------------------------------------------
// haar_2d_decompose_with_gaps
// One level of a 2D Haar decomposition over a sample grid with undefined
// cells: stores samples, returns the four coefficients of a 2x2 block.
// ----------------------------------------------------------------------------
module haar_2d_decompose_with_gaps import h2d_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output out_item_t             out_item,
  output logic                  out_valid,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg_r;
  ctl_cmd_t cmd;

  // configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cols_in_use     <= SIZE_W'(64);
      cfg_r.rows_in_use     <= SIZE_W'(64);
      cfg_r.pad_cols        <= 1'b0;
      cfg_r.pad_rows        <= 1'b0;
      cfg_r.missing_marker  <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      cfg_r.swap_on_missing <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_COLS_IN_USE:     cfg_r.cols_in_use     <= cfg_data[SIZE_W-1:0];
        CFG_ROWS_IN_USE:     cfg_r.rows_in_use     <= cfg_data[SIZE_W-1:0];
        CFG_PAD_COLS:        cfg_r.pad_cols        <= cfg_data[0];
        CFG_PAD_ROWS:        cfg_r.pad_rows        <= cfg_data[0];
        CFG_MISSING_MARKER:  cfg_r.missing_marker  <= cfg_data[SAMPLE_W-1:0];
        CFG_SWAP_ON_MISSING: cfg_r.swap_on_missing <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  h2d_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_item.action),
    .busy   (busy),
    .cmd    (cmd)
  );

  h2d_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .out_item  (out_item),
    .out_valid (out_valid)
  );

endmodule
